>>> hdl/svmdcd_pkg.sv
// shared constants, codes, state type and control structs of the svm coordinate descent block
`timescale 1ns / 1ps
package svmdcd_pkg;

   // default sizes
   localparam int unsigned NUM_FEATURES_DEF = 4096;
   localparam int unsigned NUM_SAMPLES_DEF  = 4096;
   localparam int unsigned MAX_NONZEROS_DEF = 256;

   // input command codes
   localparam logic [1:0] CMD_ENTRY    = 2'd0;
   localparam logic [1:0] CMD_PASS_END = 2'd1;
   localparam logic [1:0] CMD_READ     = 2'd2;

   // result kind codes
   localparam logic [1:0] KIND_SAMPLE = 2'd0;
   localparam logic [1:0] KIND_PASS   = 2'd1;
   localparam logic [1:0] KIND_WEIGHT = 2'd2;

   // register indexes
   localparam logic [1:0] CSR_COST_LIMIT = 2'd0;
   localparam logic [1:0] CSR_TOLERANCE  = 2'd1;
   localparam logic [1:0] CSR_MAX_PASSES = 2'd2;

   // register reset values
   localparam logic [30:0] COST_LIMIT_RST = 31'd65536;
   localparam logic [30:0] TOLERANCE_RST  = 31'd6554;
   localparam logic [15:0] MAX_PASSES_RST = 16'd1000;

   // infinity codes of the bars and pass extremes
   localparam logic signed [32:0] PINF_CODE = 33'sh0_FFFF_FFFF;
   localparam logic signed [32:0] NINF_CODE = 33'sh1_0000_0000;

   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_E_READ,
      ST_E_MUL,
      ST_E_ACC,
      ST_G,
      ST_PG,
      ST_DEC,
      ST_DIV,
      ST_RP_INIT,
      ST_RP_BUF,
      ST_RP_W,
      ST_RP_UPD,
      ST_ALPHA_WR,
      ST_OUT_S,
      ST_PASS,
      ST_W_READ,
      ST_W_OUT
   } state_type;

   typedef struct packed {
      logic clr;
      logic capture;
      logic ent_rd;
      logic ent_mul;
      logic ent_acc;
      logic g_calc;
      logic pg_calc;
      logic newa_load;
      logic div_start;
      logic rp_init;
      logic rp_buf_rd;
      logic rp_w_rd;
      logic rp_upd;
      logic alpha_wr;
      logic out_sample;
      logic pass_end;
      logic wt_rd;
      logic out_weight;
   } ctrl_cmd_type;

   typedef struct packed {
      logic clr_last;
      logic last;
      logic pg_zero;
      logic norm_zero;
      logic div_done;
      logic rp_done;
      logic slot_free;
   } dp_status_type;

endpackage

>>> hdl/svm_dual_coordinate_descent.sv
// Dual coordinate descent SVM engine, one item at a time.
// Sample entry: read, multiply and accumulate states from accept to next ready; the last entry
// adds gradient, projected gradient and decision states, then, when a step is taken, a restoring
// divide when the norm is non-zero and a weight replay of every buffered entry (weight memory
// single read and write port). A full result register stalls the item.
// After reset a clearing sweep over max(NUM_FEATURES, NUM_SAMPLES) addresses zeroes the memories.
`timescale 1ns / 1ps
module svm_dual_coordinate_descent
   import svmdcd_pkg::*;
#(
   parameter int unsigned NUM_FEATURES = NUM_FEATURES_DEF,
   parameter int unsigned NUM_SAMPLES  = NUM_SAMPLES_DEF,
   parameter int unsigned MAX_NONZEROS = MAX_NONZEROS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_command,
   input  logic [11:0]        req_sample_index,
   input  logic               req_label_positive,
   input  logic [11:0]        req_feature_index,
   input  logic signed [31:0] req_feature_value,
   input  logic               req_last_entry,
   input  logic               req_full_set,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_result_kind,
   output logic [11:0]        rsp_sample_out,
   output logic [30:0]        rsp_alpha_out,
   output logic signed [31:0] rsp_projected_gradient,
   output logic               rsp_keep_active,
   output logic               rsp_converged,
   output logic               rsp_restore_full_set,
   output logic signed [31:0] rsp_weight_value
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   // sequencer
   svmdcd_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_command),
      .req_ready   (req_ready),
      .status      (status),
      .cmd         (cmd)
   );

   // datapath
   svmdcd_dpath #(
      .NUM_FEATURES (NUM_FEATURES),
      .NUM_SAMPLES  (NUM_SAMPLES),
      .MAX_NONZEROS (MAX_NONZEROS)
   ) u_dpath (
      .clock                  (clock),
      .reset                  (reset),
      .cmd                    (cmd),
      .status                 (status),
      .req_sample_index       (req_sample_index),
      .req_label_positive     (req_label_positive),
      .req_feature_index      (req_feature_index),
      .req_feature_value      (req_feature_value),
      .req_last_entry         (req_last_entry),
      .req_full_set           (req_full_set),
      .csr_valid              (csr_valid),
      .csr_ready              (csr_ready),
      .csr_index              (csr_index),
      .csr_data               (csr_data),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_result_kind        (rsp_result_kind),
      .rsp_sample_out         (rsp_sample_out),
      .rsp_alpha_out          (rsp_alpha_out),
      .rsp_projected_gradient (rsp_projected_gradient),
      .rsp_keep_active        (rsp_keep_active),
      .rsp_converged          (rsp_converged),
      .rsp_restore_full_set   (rsp_restore_full_set),
      .rsp_weight_value       (rsp_weight_value)
   );

endmodule

>>> hdl/svmdcd_div.sv
// restoring divider, one quotient bit per cycle, for the coordinate step
`timescale 1ns / 1ps
module svmdcd_div
   import svmdcd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] magnitude,
   input  logic [63:0] divisor,
   output logic        done,
   output logic [63:0] quotient
);

   localparam int unsigned QW = 64;

   logic [63:0] rem_ff, rem_in;
   logic [63:0] quo_ff, quo_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [64:0] trial;
   logic        ge;

   // one shift and trial subtract per cycle
   always_comb begin
      trial   = {rem_ff, quo_ff[QW-1]};
      ge      = trial >= {1'b0, divisor};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         rem_in  = '0;
         quo_in  = {magnitude, 32'd0};
         cnt_in  = '0;
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         rem_in = ge ? 64'(trial - {1'b0, divisor}) : trial[63:0];
         quo_in = {quo_ff[QW-2:0], ge};
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == 7'(QW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

>>> hdl/svmdcd_ctrl.sv
// sequencer of the coordinate descent block
`timescale 1ns / 1ps
module svmdcd_ctrl
   import svmdcd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic [1:0]    req_command,
   output logic          req_ready,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clr = 1'b1;
            if (status.clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               case (req_command)
                  CMD_ENTRY:    state_in = ST_E_READ;
                  CMD_PASS_END: state_in = ST_PASS;
                  CMD_READ:     state_in = ST_W_READ;
                  default:      state_in = ST_IDLE;
               endcase
            end
         end
         ST_E_READ: begin
            cmd.ent_rd = 1'b1;
            state_in   = ST_E_MUL;
         end
         ST_E_MUL: begin
            cmd.ent_mul = 1'b1;
            state_in    = ST_E_ACC;
         end
         ST_E_ACC: begin
            cmd.ent_acc = 1'b1;
            state_in    = status.last ? ST_G : ST_IDLE;
         end
         ST_G: begin
            cmd.g_calc = 1'b1;
            state_in   = ST_PG;
         end
         ST_PG: begin
            cmd.pg_calc = 1'b1;
            state_in    = ST_DEC;
         end
         ST_DEC: begin
            if (status.pg_zero) begin
               cmd.newa_load = 1'b1;
               state_in      = ST_OUT_S;
            end else if (status.norm_zero) begin
               cmd.newa_load = 1'b1;
               state_in      = ST_RP_INIT;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV;
            end
         end
         ST_DIV: begin
            if (status.div_done) begin
               cmd.newa_load = 1'b1;
               state_in      = ST_RP_INIT;
            end
         end
         ST_RP_INIT: begin
            cmd.rp_init = 1'b1;
            state_in    = ST_RP_BUF;
         end
         ST_RP_BUF: begin
            if (status.rp_done) begin
               state_in = ST_ALPHA_WR;
            end else begin
               cmd.rp_buf_rd = 1'b1;
               state_in      = ST_RP_W;
            end
         end
         ST_RP_W: begin
            cmd.rp_w_rd = 1'b1;
            state_in    = ST_RP_UPD;
         end
         ST_RP_UPD: begin
            cmd.rp_upd = 1'b1;
            state_in   = ST_RP_BUF;
         end
         ST_ALPHA_WR: begin
            cmd.alpha_wr = 1'b1;
            state_in     = ST_OUT_S;
         end
         ST_OUT_S: begin
            if (status.slot_free) begin
               cmd.out_sample = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         ST_PASS: begin
            if (status.slot_free) begin
               cmd.pass_end = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_W_READ: begin
            cmd.wt_rd = 1'b1;
            state_in  = ST_W_OUT;
         end
         ST_W_OUT: begin
            if (status.slot_free) begin
               cmd.out_weight = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

>>> hdl/svmdcd_dpath.sv
// datapath: memories, sums, step arithmetic, registers and result register
`timescale 1ns / 1ps
module svmdcd_dpath
   import svmdcd_pkg::*;
#(
   parameter int unsigned NUM_FEATURES = NUM_FEATURES_DEF,
   parameter int unsigned NUM_SAMPLES  = NUM_SAMPLES_DEF,
   parameter int unsigned MAX_NONZEROS = MAX_NONZEROS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  ctrl_cmd_type       cmd,
   output dp_status_type      status,
   input  logic [11:0]        req_sample_index,
   input  logic               req_label_positive,
   input  logic [11:0]        req_feature_index,
   input  logic signed [31:0] req_feature_value,
   input  logic               req_last_entry,
   input  logic               req_full_set,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_result_kind,
   output logic [11:0]        rsp_sample_out,
   output logic [30:0]        rsp_alpha_out,
   output logic signed [31:0] rsp_projected_gradient,
   output logic               rsp_keep_active,
   output logic               rsp_converged,
   output logic               rsp_restore_full_set,
   output logic signed [31:0] rsp_weight_value
);

   localparam int unsigned FAW = $clog2(NUM_FEATURES);
   localparam int unsigned SAW = $clog2(NUM_SAMPLES);
   localparam int unsigned BAW = (MAX_NONZEROS > 1) ? $clog2(MAX_NONZEROS) : 1;
   localparam int unsigned CNTW = $clog2(MAX_NONZEROS + 1);
   localparam int unsigned CLR_DEPTH =
      (NUM_FEATURES > NUM_SAMPLES) ? NUM_FEATURES : NUM_SAMPLES;
   localparam int unsigned CLRW = $clog2(CLR_DEPTH);

   // configuration registers
   logic [30:0] cost_ff;
   logic [30:0] tol_ff;
   logic [15:0] maxp_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cost_ff <= COST_LIMIT_RST;
         tol_ff  <= TOLERANCE_RST;
         maxp_ff <= MAX_PASSES_RST;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_COST_LIMIT: cost_ff <= csr_data[30:0];
            CSR_TOLERANCE:  tol_ff  <= csr_data[30:0];
            CSR_MAX_PASSES: maxp_ff <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   // captured item
   logic [11:0]        si_ff, fi_ff;
   logic               pos_ff, last_ff, full_set_ff;
   logic signed [31:0] val_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         si_ff       <= req_sample_index;
         pos_ff      <= req_label_positive;
         fi_ff       <= req_feature_index;
         val_ff      <= req_feature_value;
         last_ff     <= req_last_entry;
         full_set_ff <= req_full_set;
      end
   end

   logic           fi_ok, si_ok;
   logic [FAW-1:0] fi_addr;
   logic [SAW-1:0] si_addr;

   assign fi_ok   = 32'(fi_ff) < NUM_FEATURES;
   assign si_ok   = 32'(si_ff) < NUM_SAMPLES;
   assign fi_addr = FAW'(fi_ff);
   assign si_addr = SAW'(si_ff);

   // clearing sweep counter
   logic [CLRW-1:0] clr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clr) begin
         clr_ff <= clr_ff + 1'b1;
      end
   end

   // entry buffer
   logic [43:0]     bmem [MAX_NONZEROS];
   logic [43:0]     buf_rd_ff;
   logic [CNTW-1:0] count_ff;
   logic [CNTW-1:0] rp_idx_ff;
   logic            full;
   logic [11:0]     bidx;
   logic signed [31:0] bval;

   assign full = count_ff == CNTW'(MAX_NONZEROS);
   assign bidx = buf_rd_ff[43:32];
   assign bval = buf_rd_ff[31:0];

   always_ff @(posedge clock) begin
      if (cmd.ent_rd && !full) bmem[count_ff[BAW-1:0]] <= {fi_ff, val_ff};
      if (cmd.rp_buf_rd) buf_rd_ff <= bmem[rp_idx_ff[BAW-1:0]];
   end

   // weight memory
   logic signed [31:0] wmem [NUM_FEATURES];
   logic signed [31:0] w_rd_ff;
   logic               w_ok_ff;
   logic               rp_ok_ff;
   logic [FAW-1:0]     rp_addr_ff;
   logic [FAW-1:0]     w_rd_addr, w_wr_addr;
   logic               w_wr_en;
   logic signed [31:0] w_wr_data, w_new;

   always_comb begin
      w_rd_addr = cmd.rp_w_rd ? FAW'(bidx) : fi_addr;
      w_wr_en   = (cmd.clr && (32'(clr_ff) < NUM_FEATURES)) || (cmd.rp_upd && rp_ok_ff);
      w_wr_addr = cmd.clr ? FAW'(clr_ff) : rp_addr_ff;
      w_wr_data = cmd.clr ? '0 : w_new;
   end

   always_ff @(posedge clock) begin
      if (w_wr_en) wmem[w_wr_addr] <= w_wr_data;
      if (cmd.ent_rd || cmd.wt_rd || cmd.rp_w_rd) w_rd_ff <= wmem[w_rd_addr];
      if (cmd.ent_rd || cmd.wt_rd) w_ok_ff <= fi_ok;
      if (cmd.rp_w_rd) begin
         rp_ok_ff   <= 32'(bidx) < NUM_FEATURES;
         rp_addr_ff <= FAW'(bidx);
      end
   end

   // alpha memory
   logic [30:0] amem [NUM_SAMPLES];
   logic [30:0] a_rd_ff;
   logic        a_ok_ff;
   logic [30:0] newa_ff;

   always_ff @(posedge clock) begin
      if (cmd.clr && (32'(clr_ff) < NUM_SAMPLES)) begin
         amem[SAW'(clr_ff)] <= '0;
      end else if (cmd.alpha_wr && si_ok) begin
         amem[si_addr] <= newa_ff;
      end
      if (cmd.g_calc) begin
         a_rd_ff <= amem[si_addr];
         a_ok_ff <= si_ok;
      end
   end

   // entry products
   logic signed [63:0] prod_g_ff;
   logic [63:0]        prod_sq_ff;
   logic signed [31:0] w_eff;
   logic signed [63:0] sq_s;

   assign w_eff = w_ok_ff ? w_rd_ff : '0;
   assign sq_s  = val_ff * val_ff;

   always_ff @(posedge clock) begin
      if (cmd.ent_mul) begin
         prod_g_ff  <= w_eff * val_ff;
         prod_sq_ff <= sq_s;
      end
   end

   // saturating sums
   logic signed [63:0] gsum_ff, gsum_in;
   logic [63:0]        nsum_ff, nsum_in;
   logic signed [64:0] gadd;
   logic [64:0]        nadd;
   logic               smp_clear;

   assign smp_clear = cmd.out_sample || cmd.pass_end;

   always_comb begin
      gadd = {gsum_ff[63], gsum_ff} + {prod_g_ff[63], prod_g_ff};
      if (gadd[64] != gadd[63]) begin
         gsum_in = gadd[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      end else begin
         gsum_in = gadd[63:0];
      end
      nadd    = {1'b0, nsum_ff} + {1'b0, prod_sq_ff};
      nsum_in = nadd[64] ? {64{1'b1}} : nadd[63:0];
   end

   always_ff @(posedge clock) begin
      if (reset || smp_clear) begin
         count_ff <= '0;
         gsum_ff  <= '0;
         nsum_ff  <= '0;
      end else if (cmd.ent_acc && !full) begin
         count_ff <= count_ff + 1'b1;
         gsum_ff  <= gsum_in;
         nsum_ff  <= nsum_in;
      end
   end

   // gradient g
   logic signed [31:0] g_ff;
   logic signed [47:0] s48;
   logic signed [48:0] s49;
   logic signed [49:0] t50;
   logic signed [31:0] g_in;

   always_comb begin
      s48 = gsum_ff[63:16];
      s49 = pos_ff ? {s48[47], s48} : -{s48[47], s48};
      t50 = {s49[48], s49} - 50'sd65536;
      if (t50 > 50'sd2147483647) g_in = 32'sh7FFF_FFFF;
      else if (t50 < -50'sd2147483648) g_in = 32'sh8000_0000;
      else g_in = t50[31:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.g_calc) g_ff <= g_in;
   end

   // projected gradient, shrinking test and pass extremes
   logic signed [32:0] g33, pg_in, pg_ff;
   logic signed [32:0] upper_ff, lower_ff, pmax_ff, pmin_ff;
   logic [30:0]        alpha_in, alpha_ff;
   logic               keep_in, keep_ff;

   always_comb begin
      g33      = {g_ff[31], g_ff};
      alpha_in = a_ok_ff ? a_rd_ff : '0;
      pg_in    = '0;
      if (alpha_in == '0) begin
         keep_in = g33 <= upper_ff;
         if (g_ff < 0) pg_in = g33;
      end else if (alpha_in == cost_ff) begin
         keep_in = g33 >= lower_ff;
         if (g_ff > 0) pg_in = g33;
      end else begin
         keep_in = 1'b1;
         pg_in   = g33;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.pg_calc) begin
         pg_ff    <= pg_in;
         keep_ff  <= keep_in;
         alpha_ff <= alpha_in;
      end
   end

   // step divider
   logic        gpos;
   logic [31:0] mag;
   logic        div_done;
   logic [63:0] quot;

   assign gpos = (g_ff > 0);
   assign mag  = g_ff[31] ? 32'(-g33) : g_ff;

   svmdcd_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .magnitude (mag),
      .divisor   (nsum_ff),
      .done      (div_done),
      .quotient  (quot)
   );

   // new alpha, clamped to the cost limit on both step directions
   logic [30:0] newa_in;
   logic [31:0] up_sum;
   logic [30:0] dn_diff;

   always_comb begin
      up_sum  = {1'b0, alpha_ff} + {1'b0, quot[30:0]};
      dn_diff = alpha_ff - quot[30:0];
      if (pg_ff == '0) begin
         newa_in = alpha_ff;
      end else if (nsum_ff == '0) begin
         newa_in = gpos ? '0 : cost_ff;
      end else if (gpos) begin
         if (quot >= 64'(alpha_ff)) newa_in = '0;
         else if (dn_diff > cost_ff) newa_in = cost_ff;
         else newa_in = dn_diff;
      end else if (quot >= 64'(cost_ff)) begin
         newa_in = cost_ff;
      end else begin
         newa_in = (up_sum > 32'(cost_ff)) ? cost_ff : up_sum[30:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.newa_load) newa_ff <= newa_in;
   end

   // weight replay
   logic signed [33:0] d_ff;
   logic signed [32:0] d33;
   logic signed [65:0] prod_r_ff;
   logic signed [49:0] t_r;
   logic signed [50:0] w_sum;

   assign d33 = $signed({2'b00, newa_ff}) - $signed({2'b00, alpha_ff});

   always_comb begin
      t_r   = prod_r_ff[65:16];
      w_sum = {{19{w_rd_ff[31]}}, w_rd_ff} + {t_r[49], t_r};
      if (w_sum > 51'sd2147483647) w_new = 32'sh7FFF_FFFF;
      else if (w_sum < -51'sd2147483648) w_new = 32'sh8000_0000;
      else w_new = w_sum[31:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.rp_init) begin
         d_ff      <= pos_ff ? {d33[32], d33} : -{d33[32], d33};
         rp_idx_ff <= '0;
      end else if (cmd.rp_upd) begin
         rp_idx_ff <= rp_idx_ff + 1'b1;
      end
      if (cmd.rp_w_rd) prod_r_ff <= d_ff * bval;
   end

   // pass end
   logic signed [33:0] gap;
   logic               gap_low, restore, conv;
   logic [15:0]        pcnt_ff, pcnt_in;

   always_comb begin
      gap     = {pmax_ff[32], pmax_ff} - {pmin_ff[32], pmin_ff};
      gap_low = gap < $signed({3'b000, tol_ff});
      restore = gap_low && !full_set_ff;
      pcnt_in = (pcnt_ff != 16'hFFFF) ? pcnt_ff + 16'd1 : pcnt_ff;
      conv    = (gap_low && full_set_ff) || (pcnt_in >= maxp_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pmax_ff  <= NINF_CODE;
         pmin_ff  <= PINF_CODE;
         upper_ff <= PINF_CODE;
         lower_ff <= NINF_CODE;
         pcnt_ff  <= '0;
      end else if (cmd.pass_end) begin
         pmax_ff <= NINF_CODE;
         pmin_ff <= PINF_CODE;
         pcnt_ff <= pcnt_in;
         if (restore) begin
            upper_ff <= PINF_CODE;
            lower_ff <= NINF_CODE;
         end else begin
            upper_ff <= (pmax_ff <= 0) ? PINF_CODE : pmax_ff;
            lower_ff <= (pmin_ff >= 0) ? NINF_CODE : pmin_ff;
         end
      end else if (cmd.pg_calc) begin
         if (pg_in > pmax_ff) pmax_ff <= pg_in;
         if (pg_in < pmin_ff) pmin_ff <= pg_in;
      end
   end

   // result register
   logic rsp_valid_ff;
   logic load;

   assign load = cmd.out_sample || cmd.pass_end || cmd.out_weight;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (load) begin
         rsp_result_kind        <= KIND_SAMPLE;
         rsp_sample_out         <= '0;
         rsp_alpha_out          <= '0;
         rsp_projected_gradient <= '0;
         rsp_keep_active        <= 1'b0;
         rsp_converged          <= 1'b0;
         rsp_restore_full_set   <= 1'b0;
         rsp_weight_value       <= '0;
         if (cmd.out_sample) begin
            rsp_sample_out         <= si_ff;
            rsp_alpha_out          <= newa_ff;
            rsp_projected_gradient <= pg_ff[31:0];
            rsp_keep_active        <= keep_ff;
         end else if (cmd.pass_end) begin
            rsp_result_kind      <= KIND_PASS;
            rsp_converged        <= conv;
            rsp_restore_full_set <= restore;
         end else begin
            rsp_result_kind  <= KIND_WEIGHT;
            rsp_weight_value <= w_eff;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // status to the sequencer
   always_comb begin
      status.clr_last  = clr_ff == CLRW'(CLR_DEPTH - 1);
      status.last      = last_ff;
      status.pg_zero   = pg_ff == '0;
      status.norm_zero = nsum_ff == '0;
      status.div_done  = div_done;
      status.rp_done   = rp_idx_ff == count_ff;
      status.slot_free = !rsp_valid_ff || rsp_ready;
   end

endmodule
